// ----- design/pcmmix_pkg.sv -----
// pcmmix_pkg: types, constants and sample format helpers for the PCM mixer.
// Used by pcmmix_cell, pcmmix_clamp and saturating_pcm_mixer. No dependencies.
package pcmmix_pkg;

  localparam int MAX_TRACKS       = 8;
  localparam int MAX_SAMPLE_BYTES = 4;
  localparam int SAMPLE_W         = 8 * MAX_SAMPLE_BYTES;
  localparam int SUM_W            = SAMPLE_W + 4;
  localparam int TC_W             = 4;
  localparam int NB_W             = 3;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_SIGNED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN   = 2'd3;

  localparam logic [NB_W-1:0] NB_1 = 3'd1;
  localparam logic [NB_W-1:0] NB_2 = 3'd2;
  localparam logic [NB_W-1:0] NB_3 = 3'd3;
  localparam logic [NB_W-1:0] NB_4 = 3'd4;

  typedef logic [MAX_TRACKS-1:0][SAMPLE_W-1:0] lanes_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [NB_W-1:0] nb;
    logic            twos_comp;
    logic            big_endian;
  } fmt_t;

  typedef struct packed {
    logic            valid;
    logic [TC_W-1:0] remaining;
    lanes_t          lanes;
    sum_t            sum;
  } beat_t;

  // keep the low nb bytes, reversed when big-endian; upper bytes zero
  function automatic logic [SAMPLE_W-1:0] order_bytes(input logic [SAMPLE_W-1:0] v,
                                                      input fmt_t f);
    logic [SAMPLE_W-1:0] r;
    case (f.nb)
      NB_1: r = {24'b0, v[7:0]};
      NB_2: r = f.big_endian ? {16'b0, v[7:0], v[15:8]} : {16'b0, v[15:0]};
      NB_3: r = f.big_endian ? {8'b0, v[7:0], v[15:8], v[23:16]} : {8'b0, v[23:0]};
      default: r = f.big_endian ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
    endcase
    return r;
  endfunction

  function automatic sum_t decode(input logic [SAMPLE_W-1:0] raw, input fmt_t f);
    logic [SAMPLE_W-1:0] r;
    sum_t                s;
    r = order_bytes(raw, f);
    case (f.nb)
      NB_1: s = {{28{f.twos_comp & r[7]}}, r[7:0]};
      NB_2: s = {{20{f.twos_comp & r[15]}}, r[15:0]};
      NB_3: s = {{12{f.twos_comp & r[23]}}, r[23:0]};
      default: s = {{4{f.twos_comp & r[31]}}, r[31:0]};
    endcase
    return s;
  endfunction

  function automatic sum_t fmt_hi(input fmt_t f);
    sum_t h;
    case (f.nb)
      NB_1: h = f.twos_comp ? sum_t'(36'sh7F) : sum_t'(36'shFF);
      NB_2: h = f.twos_comp ? sum_t'(36'sh7FFF) : sum_t'(36'shFFFF);
      NB_3: h = f.twos_comp ? sum_t'(36'sh7FFFFF) : sum_t'(36'shFFFFFF);
      default: h = f.twos_comp ? sum_t'(36'sh7FFFFFFF) : sum_t'(36'shFFFFFFFF);
    endcase
    return h;
  endfunction

  function automatic sum_t fmt_lo(input fmt_t f);
    sum_t l;
    case (f.nb)
      NB_1: l = f.twos_comp ? -sum_t'(36'sh80) : '0;
      NB_2: l = f.twos_comp ? -sum_t'(36'sh8000) : '0;
      NB_3: l = f.twos_comp ? -sum_t'(36'sh800000) : '0;
      default: l = f.twos_comp ? -sum_t'(36'sh80000000) : '0;
    endcase
    return l;
  endfunction

endpackage

// ----- design/pcmmix_cell.sv -----
// pcmmix_cell: one accumulate cell of the mixer chain.
// Decodes lane 0 and, while tracks remain, adds it to the running sum; shifts the lanes down.
// Depends on pcmmix_pkg.
module pcmmix_cell (
  input  logic               clk,
  input  logic               rst,
  input  pcmmix_pkg::fmt_t  fmt,
  input  pcmmix_pkg::beat_t din,
  output pcmmix_pkg::beat_t dout
);

  logic                          use_lane;
  pcmmix_pkg::sum_t              sum_next;
  logic [pcmmix_pkg::TC_W-1:0]   remaining_next;
  pcmmix_pkg::lanes_t            lanes_next;

  assign use_lane       = (din.remaining != '0);
  assign sum_next       = use_lane ? din.sum + pcmmix_pkg::decode(din.lanes[0], fmt)
                                   : din.sum;
  assign remaining_next = use_lane ? din.remaining - 1'b1 : '0;
  assign lanes_next     = din.lanes >> pcmmix_pkg::SAMPLE_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.remaining <= remaining_next;
    dout.lanes     <= lanes_next;
    dout.sum       <= sum_next;
  end

endmodule

// ----- design/pcmmix_clamp.sv -----
// pcmmix_clamp: saturates the final sum to the sample range and re-encodes it.
// Output register with strobe. Depends on pcmmix_pkg.
module pcmmix_clamp (
  input  logic                              clk,
  input  logic                              rst,
  input  pcmmix_pkg::fmt_t                 fmt,
  input  pcmmix_pkg::beat_t                din,
  output logic                              done,
  output logic [pcmmix_pkg::SAMPLE_W-1:0]   mixed_sample
);

  pcmmix_pkg::sum_t                  hi;
  pcmmix_pkg::sum_t                  lo;
  pcmmix_pkg::sum_t                  sat;
  logic [pcmmix_pkg::SAMPLE_W-1:0]   sample_next;

  assign hi = pcmmix_pkg::fmt_hi(fmt);
  assign lo = pcmmix_pkg::fmt_lo(fmt);

  always_comb begin
    if (din.sum < lo) begin
      sat = lo;
    end else if (din.sum > hi) begin
      sat = hi;
    end else begin
      sat = din.sum;
    end
    sample_next = pcmmix_pkg::order_bytes(sat[pcmmix_pkg::SAMPLE_W-1:0], fmt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    mixed_sample <= sample_next;
  end

endmodule

// ----- design/saturating_pcm_mixer.sv -----
// saturating_pcm_mixer: top level; config registers, chain of 8 accumulate cells, clamp.
// A taken start reaches done through the cell registers (one cell per track), then the clamp register.
// Throughput: one frame per cycle; busy stays low and cfg_ready stays high.
// Reset clears all in-flight frames and restores the default format (2 tracks,
// signed, 2 bytes, little-endian). The receiver cannot stall. Depends on pcmmix_pkg,
// pcmmix_cell and pcmmix_clamp.
module saturating_pcm_mixer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [pcmmix_pkg::SAMPLE_W-1:0]     track0_sample,
  input  logic [pcmmix_pkg::SAMPLE_W-1:0]     track1_sample,
  input  logic [pcmmix_pkg::SAMPLE_W-1:0]     track2_sample,
  input  logic [pcmmix_pkg::SAMPLE_W-1:0]     track3_sample,
  input  logic [pcmmix_pkg::SAMPLE_W-1:0]     track4_sample,
  input  logic [pcmmix_pkg::SAMPLE_W-1:0]     track5_sample,
  input  logic [pcmmix_pkg::SAMPLE_W-1:0]     track6_sample,
  input  logic [pcmmix_pkg::SAMPLE_W-1:0]     track7_sample,
  output logic                                done,
  output logic [pcmmix_pkg::SAMPLE_W-1:0]     mixed_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcmmix_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcmmix_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [pcmmix_pkg::TC_W-1:0]  track_count;
  logic                         is_signed_fmt;
  logic [pcmmix_pkg::NB_W-1:0]  sample_bytes;
  logic                         big_endian_fmt;

  pcmmix_pkg::fmt_t             fmt;
  logic [pcmmix_pkg::TC_W-1:0]  tracks;
  pcmmix_pkg::beat_t            chain [0:pcmmix_pkg::MAX_TRACKS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_count    <= 4'd2;
      is_signed_fmt  <= 1'b1;
      sample_bytes   <= 3'd2;
      big_endian_fmt <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcmmix_pkg::CFG_TRACK_COUNT:  track_count    <= cfg_data;
        pcmmix_pkg::CFG_IS_SIGNED:    is_signed_fmt  <= cfg_data[0];
        pcmmix_pkg::CFG_SAMPLE_BYTES: sample_bytes   <= cfg_data[pcmmix_pkg::NB_W-1:0];
        pcmmix_pkg::CFG_BIG_ENDIAN:   big_endian_fmt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sample_bytes == '0) begin
      fmt.nb = pcmmix_pkg::NB_1;
    end else if (sample_bytes > pcmmix_pkg::NB_4) begin
      fmt.nb = pcmmix_pkg::NB_4;
    end else begin
      fmt.nb = sample_bytes;
    end
    fmt.twos_comp  = is_signed_fmt;
    fmt.big_endian = big_endian_fmt;
    if (track_count > pcmmix_pkg::TC_W'(pcmmix_pkg::MAX_TRACKS)) begin
      tracks = pcmmix_pkg::TC_W'(pcmmix_pkg::MAX_TRACKS);
    end else begin
      tracks = track_count;
    end
  end

  assign chain[0].valid     = start && !busy;
  assign chain[0].remaining = tracks;
  assign chain[0].lanes     = {track7_sample, track6_sample, track5_sample, track4_sample,
                               track3_sample, track2_sample, track1_sample, track0_sample};
  assign chain[0].sum       = '0;

  for (genvar k = 0; k < pcmmix_pkg::MAX_TRACKS; k++) begin : g_cell
    pcmmix_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .fmt  (fmt),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  pcmmix_clamp u_clamp (
    .clk          (clk),
    .rst          (rst),
    .fmt          (fmt),
    .din          (chain[pcmmix_pkg::MAX_TRACKS]),
    .done         (done),
    .mixed_sample (mixed_sample)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##9 done)
    else $error("frame did not complete after 9 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 9))
    else $error("result without a matching start");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (done && fmt.nb == pcmmix_pkg::NB_1) |-> mixed_sample[31:8] == '0)
    else $error("unused output bytes not zero");

endmodule
